### rtl/core/bsrt_pkg.sv
// Shared types and constants for the bad sector remap table.
package bsrt_pkg;

   localparam int SECTOR_W    = 48;
   localparam int COUNT_W     = 16;
   localparam int STRIDE_W    = 13;
   localparam int SLOTS_CFG_W = 9;
   localparam int KIND_W      = 3;
   localparam int TSEC_W      = 4;
   localparam int TIDX_W      = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 48;
   localparam int REM_STAGES  = COUNT_W;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_TRANSLATE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PROBE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COMMIT    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SKIP      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SECTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE       = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_scan;
      logic scan_done;
      logic pipe_idle;
   } dp_status_type;

endpackage

### rtl/core/bsrt_if.sv
// Request and response channel interfaces for the bad sector remap table.
interface bsrt_req_if
   import bsrt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SECTOR_W-1:0] sector;
   logic [COUNT_W-1:0]  sector_count;

   modport source (output valid, output kind, output sector, output sector_count,
                   input ready);
   modport sink   (input valid, input kind, input sector, input sector_count,
                   output ready);
endinterface

interface bsrt_rsp_if
   import bsrt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic                hit;
   logic [SECTOR_W-1:0] sector_out;
   logic [TSEC_W-1:0]   table_sector;
   logic [TIDX_W-1:0]   table_index;
   logic                status;

   modport source (output valid, output hit, output sector_out, output table_sector,
                   output table_index, output status, input ready);
   modport sink   (input valid, input hit, input sector_out, input table_sector,
                   input table_index, input status, output ready);
endinterface

### rtl/core/bad_sector_remap_table_core.sv
// Top level of the bad sector remap table.
//
// Requests arrive on req_ch (valid/ready); each item gives one response item
// on rsp_ch. Kinds: translate, probe range, peek next free slot, commit a bad
// sector into the next slot, skip the next slot. Config registers are written
// on csr_we with csr_index / csr_wdata; the user must write them only while the
// block is idle, which the block itself leaves unchecked.
// Translate and probe scan every used slot through the slot memory read
// port, one slot per cycle, followed by a 16-stage remainder pipeline for the
// stride test. Peek, commit, skip and unknown kinds go from capture straight
// to the result without a scan. One item is in flight at a time.
//
// The response sits in an output register; while the receiver stalls, the
// next request is still accepted and worked on, and its result is loaded only
// once the previous response has been taken.
//
// Reset (synchronous, active high) clears the fill count, the table sector
// counters and the config registers; slot contents need no clearing since
// only slots below the fill count are ever read.
module bad_sector_remap_table_core
   import bsrt_pkg::*;
#(
   parameter int MAX_SLOTS                = 256,
   parameter int ENTRIES_PER_TABLE_SECTOR = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   bsrt_req_if.sink              req_ch,
   bsrt_rsp_if.source            rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // controller: handshakes and sequencing only
   bsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: table storage, scan and result payload
   bsrt_datapath #(
      .MAX_SLOTS                (MAX_SLOTS),
      .ENTRIES_PER_TABLE_SECTOR (ENTRIES_PER_TABLE_SECTOR)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_ch.kind),
      .req_sector       (req_ch.sector),
      .req_sector_count (req_ch.sector_count),
      .cmd              (cmd),
      .status           (status),
      .rsp_hit          (rsp_ch.hit),
      .rsp_sector_out   (rsp_ch.sector_out),
      .rsp_table_sector (rsp_ch.table_sector),
      .rsp_table_index  (rsp_ch.table_index),
      .rsp_status       (rsp_ch.status)
   );

endmodule

### rtl/core/bsrt_rem_pipe.sv
// Pipelined remainder unit: one bit of the dividend per stage, zero test at the end.
module bsrt_rem_pipe
   import bsrt_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [COUNT_W-1:0]  in_d,
   input  logic [IDX_W-1:0]    in_idx,
   input  logic [STRIDE_W-1:0] stride,
   output logic                out_vld,
   output logic                out_zero,
   output logic [COUNT_W-1:0]  out_d,
   output logic [IDX_W-1:0]    out_idx,
   output logic                busy
);

   logic                vld_ff [REM_STAGES];
   logic [STRIDE_W-1:0] r_ff   [REM_STAGES];
   logic [COUNT_W-1:0]  d_ff   [REM_STAGES];
   logic [IDX_W-1:0]    idx_ff [REM_STAGES];

   logic                vld_in [REM_STAGES];
   logic [STRIDE_W-1:0] r_in   [REM_STAGES];
   logic [COUNT_W-1:0]  d_in   [REM_STAGES];
   logic [IDX_W-1:0]    idx_in [REM_STAGES];

   always_comb begin
      logic                pv;
      logic [COUNT_W-1:0]  pd;
      logic [STRIDE_W-1:0] pr;
      logic [IDX_W-1:0]    pi;
      logic [STRIDE_W:0]   t;
      for (int s = 0; s < REM_STAGES; s++) begin
         if (s == 0) begin
            pv = in_vld;
            pd = in_d;
            pr = '0;
            pi = in_idx;
         end else begin
            pv = vld_ff[s-1];
            pd = d_ff[s-1];
            pr = r_ff[s-1];
            pi = idx_ff[s-1];
         end
         // shift in the next dividend bit, subtract if it fits
         t = {pr, pd[COUNT_W-1-s]};
         if (t >= {1'b0, stride}) begin
            t = t - {1'b0, stride};
         end
         vld_in[s] = pv;
         r_in[s]   = t[STRIDE_W-1:0];
         d_in[s]   = pd;
         idx_in[s] = pi;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < REM_STAGES; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < REM_STAGES; s++) begin
         r_ff[s]   <= r_in[s];
         d_ff[s]   <= d_in[s];
         idx_ff[s] <= idx_in[s];
      end
   end

   always_comb begin
      busy = 1'b0;
      for (int s = 0; s < REM_STAGES; s++) begin
         busy = busy | vld_ff[s];
      end
   end

   assign out_vld  = vld_ff[REM_STAGES-1];
   assign out_zero = (r_ff[REM_STAGES-1] == '0);
   assign out_d    = d_ff[REM_STAGES-1];
   assign out_idx  = idx_ff[REM_STAGES-1];

endmodule

### rtl/core/bsrt_datapath.sv
// Datapath: config registers, slot memory, scan pipeline, slot counters, result register.
module bsrt_datapath
   import bsrt_pkg::*;
#(
   parameter int MAX_SLOTS                = 256,
   parameter int ENTRIES_PER_TABLE_SECTOR = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [SECTOR_W-1:0]   req_sector,
   input  logic [COUNT_W-1:0]    req_sector_count,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic                  rsp_hit,
   output logic [SECTOR_W-1:0]   rsp_sector_out,
   output logic [TSEC_W-1:0]     rsp_table_sector,
   output logic [TIDX_W-1:0]     rsp_table_index,
   output logic                  rsp_status
);

   localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W   = (CNT_W > SLOTS_CFG_W) ? CNT_W : SLOTS_CFG_W;
   localparam int TIDX_CW = (ENTRIES_PER_TABLE_SECTOR > 1) ?
                            $clog2(ENTRIES_PER_TABLE_SECTOR) : 1;
   localparam logic [TIDX_CW-1:0] TIDX_LAST = TIDX_CW'(ENTRIES_PER_TABLE_SECTOR - 1);

   // config
   logic [SECTOR_W-1:0]    first_ff;
   logic [SLOTS_CFG_W-1:0] nslots_ff;
   logic [STRIDE_W-1:0]    stride_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff      <= '0;
         nslots_ff     <= '0;
         stride_cfg_ff <= STRIDE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_SECTOR: first_ff      <= csr_wdata[SECTOR_W-1:0];
            CSR_SLOTS:        nslots_ff     <= csr_wdata[SLOTS_CFG_W-1:0];
            CSR_STRIDE:       stride_cfg_ff <= csr_wdata[STRIDE_W-1:0];
            default:          ;
         endcase
      end
   end

   // latched item
   logic [KIND_W-1:0]   kind_ff;
   logic [SECTOR_W-1:0] sector_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [STRIDE_W-1:0] stride_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         sector_ff <= req_sector;
         // translate is a probe of one sector at stride one
         if (req_kind == KIND_TRANSLATE) begin
            count_ff  <= COUNT_W'(1);
            stride_ff <= STRIDE_W'(1);
         end else begin
            count_ff  <= req_sector_count;
            stride_ff <= (stride_cfg_ff == '0) ? STRIDE_W'(1) : stride_cfg_ff;
         end
      end
   end

   // slot allocation state
   logic [CNT_W-1:0]   slots_used_ff, slots_used_in;
   logic [TSEC_W-1:0]  tsec_ff, tsec_in;
   logic [TIDX_CW-1:0] tidx_ff, tidx_in;
   logic               full;
   logic               advance;
   logic [IDX_W-1:0]   next_slot;

   assign full = (CMP_W'(slots_used_ff) >= CMP_W'(nslots_ff)) ||
                 (slots_used_ff >= CNT_W'(MAX_SLOTS));
   assign next_slot = slots_used_ff[IDX_W-1:0];
   assign advance = cmd.finish && !full &&
                    ((kind_ff == KIND_COMMIT) || (kind_ff == KIND_SKIP));

   always_comb begin
      slots_used_in = slots_used_ff;
      tsec_in       = tsec_ff;
      tidx_in       = tidx_ff;
      if (advance) begin
         slots_used_in = slots_used_ff + CNT_W'(1);
         if (tidx_ff == TIDX_LAST) begin
            tidx_in = '0;
            tsec_in = tsec_ff + TSEC_W'(1);
         end else begin
            tidx_in = tidx_ff + TIDX_CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_used_ff <= '0;
         tsec_ff       <= '0;
         tidx_ff       <= '0;
      end else begin
         slots_used_ff <= slots_used_in;
         tsec_ff       <= tsec_in;
         tidx_ff       <= tidx_in;
      end
   end

   // slot memory: {valid, bad sector}; only slots below the fill count are read
   logic [SECTOR_W:0] slot_mem [MAX_SLOTS];
   logic [CNT_W-1:0]  scan_idx_ff;
   logic [SECTOR_W:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_mem[next_slot] <= {(kind_ff == KIND_COMMIT), sector_ff};
      end
      if (cmd.issue) begin
         rd_data_ff <= slot_mem[scan_idx_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         if (cmd.capture) begin
            scan_idx_ff <= '0;
         end else if (cmd.issue) begin
            scan_idx_ff <= scan_idx_ff + CNT_W'(1);
         end
      end
   end

   // distance and range test
   logic [SECTOR_W-1:0] sec_delta;
   logic                in_range;
   logic                a_vld_ff;
   logic [COUNT_W-1:0]  a_d_ff;
   logic [IDX_W-1:0]    a_idx_ff;

   assign sec_delta = rd_data_ff[SECTOR_W-1:0] - sector_ff;
   assign in_range  = rd_data_ff[SECTOR_W] && (sec_delta < SECTOR_W'(count_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= rd_vld_ff && in_range;
      end
   end

   always_ff @(posedge clock) begin
      a_d_ff   <= sec_delta[COUNT_W-1:0];
      a_idx_ff <= rd_idx_ff;
   end

   // stride test
   logic               rem_vld;
   logic               rem_zero;
   logic [COUNT_W-1:0] rem_d;
   logic [IDX_W-1:0]   rem_idx;
   logic               rem_busy;

   bsrt_rem_pipe #(
      .IDX_W (IDX_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (a_vld_ff),
      .in_d     (a_d_ff),
      .in_idx   (a_idx_ff),
      .stride   (stride_ff),
      .out_vld  (rem_vld),
      .out_zero (rem_zero),
      .out_d    (rem_d),
      .out_idx  (rem_idx),
      .busy     (rem_busy)
   );

   // nearest hit; slots arrive in ascending order so ties keep the lowest slot
   logic               best_hit_ff;
   logic [COUNT_W-1:0] best_d_ff;
   logic [IDX_W-1:0]   best_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_hit_ff <= 1'b0;
      end else if (cmd.capture) begin
         best_hit_ff <= 1'b0;
      end else if (rem_vld && rem_zero && (!best_hit_ff || (rem_d < best_d_ff))) begin
         best_hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rem_vld && rem_zero && (!best_hit_ff || (rem_d < best_d_ff))) begin
         best_d_ff   <= rem_d;
         best_idx_ff <= rem_idx;
      end
   end

   assign status.req_is_scan = (req_kind == KIND_TRANSLATE) || (req_kind == KIND_PROBE);
   assign status.scan_done   = (scan_idx_ff >= slots_used_ff);
   assign status.pipe_idle   = !rd_vld_ff && !a_vld_ff && !rem_busy;

   // result
   logic                hit_in;
   logic [SECTOR_W-1:0] sout_in;
   logic [TSEC_W-1:0]   tsec_out_in;
   logic [TIDX_W-1:0]   tidx_out_in;
   logic                status_in;

   always_comb begin
      hit_in      = 1'b0;
      sout_in     = sector_ff;
      tsec_out_in = '0;
      tidx_out_in = '0;
      status_in   = STATUS_OK;
      unique case (kind_ff)
         KIND_TRANSLATE, KIND_PROBE: begin
            hit_in = best_hit_ff;
            if (best_hit_ff) begin
               sout_in = first_ff + SECTOR_W'(best_idx_ff);
            end
         end
         KIND_PEEK, KIND_COMMIT, KIND_SKIP: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else if (kind_ff == KIND_PEEK) begin
               sout_in = first_ff + SECTOR_W'(slots_used_ff);
            end else if (kind_ff == KIND_COMMIT) begin
               sout_in     = first_ff + SECTOR_W'(slots_used_ff);
               tsec_out_in = tsec_ff;
               tidx_out_in = TIDX_W'(tidx_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_hit          <= hit_in;
         rsp_sector_out   <= sout_in;
         rsp_table_sector <= tsec_out_in;
         rsp_table_index  <= tidx_out_in;
         rsp_status       <= status_in;
      end
   end

endmodule

### rtl/core/bsrt_ctrl.sv
// Controller: sequences capture, slot scan, pipeline drain and result hand-off.
module bsrt_ctrl
   import bsrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.req_is_scan ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_idle) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### tb/sv/bsrt_remap_checker.sv
// Checker for the bad sector remap table: watches the channels, predicts each result and compares.
module bsrt_remap_checker
   import bsrt_pkg::*;
#(
   parameter int MAX_SLOTS                = 256,
   parameter int ENTRIES_PER_TABLE_SECTOR = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   bsrt_req_if                   req_ch,
   bsrt_rsp_if                   rsp_ch,
   output int                    fail_count,
   output int                    due_count,
   output int                    checked_count
);

   typedef struct packed {
      logic                hit;
      logic [SECTOR_W-1:0] sector_out;
      logic [TSEC_W-1:0]   table_sector;
      logic [TIDX_W-1:0]   table_index;
      logic                status;
   } remap_result_type;

   // shadow of the relocation table and its registers
   logic [SECTOR_W-1:0]    slot_sector [MAX_SLOTS];
   logic                   slot_taken  [MAX_SLOTS];
   int                     fill;
   logic [SECTOR_W-1:0]    base_sector;
   logic [SLOTS_CFG_W-1:0] slot_limit;
   logic [STRIDE_W-1:0]    stride_cfg;

   remap_result_type remap_results_due [$];
   int   fails;
   int   checked;
   logic result_bad;

   task automatic compute_remap(input  logic [KIND_W-1:0]   kind,
                                input  logic [SECTOR_W-1:0] sec,
                                input  logic [COUNT_W-1:0]  cnt,
                                output remap_result_type    res);
      logic [SECTOR_W-1:0] delta;
      logic [SECTOR_W-1:0] best;
      logic [STRIDE_W-1:0] step;
      logic                full;
      res            = '0;
      res.sector_out = sec;
      best           = '0;
      step           = (stride_cfg == '0) ? STRIDE_W'(1) : stride_cfg;
      full           = (fill >= int'(slot_limit)) || (fill >= MAX_SLOTS);
      case (kind)
         KIND_TRANSLATE: begin
            // lowest slot wins on duplicate bad sectors
            for (int k = 0; k < MAX_SLOTS; k++) begin
               if (slot_taken[k] && !res.hit && slot_sector[k] == sec) begin
                  res.hit        = 1'b1;
                  res.sector_out = base_sector + SECTOR_W'(k);
               end
            end
         end
         KIND_PROBE: begin
            // nearest stepped sector from range start, distance mod 2^48
            for (int k = 0; k < MAX_SLOTS; k++) begin
               if (slot_taken[k]) begin
                  delta = slot_sector[k] - sec;
                  if (delta < cnt && (delta % step) == 0 && (!res.hit || delta < best)) begin
                     res.hit        = 1'b1;
                     best           = delta;
                     res.sector_out = base_sector + SECTOR_W'(k);
                  end
               end
            end
         end
         KIND_PEEK, KIND_COMMIT, KIND_SKIP: begin
            if (full) begin
               res.status = STATUS_FULL;
            end else if (kind == KIND_PEEK) begin
               res.sector_out = base_sector + SECTOR_W'(fill);
            end else if (kind == KIND_COMMIT) begin
               slot_sector[fill] = sec;
               slot_taken[fill]  = 1'b1;
               res.sector_out    = base_sector + SECTOR_W'(fill);
               res.table_sector  = TSEC_W'(fill / ENTRIES_PER_TABLE_SECTOR);
               res.table_index   = TIDX_W'(fill % ENTRIES_PER_TABLE_SECTOR);
               fill++;
            end else begin
               fill++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [SECTOR_W-1:0] want_v,
                              input logic [SECTOR_W-1:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want_v, got_v);
         result_bad = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      remap_result_type want;
      remap_result_type seen;
      if (reset) begin
         for (int k = 0; k < MAX_SLOTS; k++) begin
            slot_sector[k] = '0;
            slot_taken[k]  = 1'b0;
         end
         fill        = 0;
         base_sector = '0;
         slot_limit  = '0;
         stride_cfg  = STRIDE_W'(1);
         remap_results_due.delete();
         fails   = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_SECTOR: base_sector = csr_wdata[SECTOR_W-1:0];
               CSR_SLOTS:        slot_limit  = csr_wdata[SLOTS_CFG_W-1:0];
               CSR_STRIDE:       stride_cfg  = csr_wdata[STRIDE_W-1:0];
               default: ;
            endcase
         end
         // results first: a result never belongs to an item taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.hit          = rsp_ch.hit;
            seen.sector_out   = rsp_ch.sector_out;
            seen.table_sector = rsp_ch.table_sector;
            seen.table_index  = rsp_ch.table_index;
            seen.status       = rsp_ch.status;
            if (remap_results_due.size() == 0) begin
               $display("%0t: result item with none expected: expected nothing, got %h",
                        $time, seen);
               fails++;
            end else begin
               want       = remap_results_due.pop_front();
               result_bad = 1'b0;
               check_field("hit",          SECTOR_W'(want.hit),          SECTOR_W'(seen.hit));
               check_field("sector_out",   want.sector_out,              seen.sector_out);
               check_field("table_sector", SECTOR_W'(want.table_sector), SECTOR_W'(seen.table_sector));
               check_field("table_index",  SECTOR_W'(want.table_index),  SECTOR_W'(seen.table_index));
               check_field("status",       SECTOR_W'(want.status),       SECTOR_W'(seen.status));
               if (result_bad) fails++;
               checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            compute_remap(req_ch.kind, req_ch.sector, req_ch.sector_count, want);
            remap_results_due.push_back(want);
         end
      end
      fail_count    <= fails;
      due_count     <= remap_results_due.size();
      checked_count <= checked;
   end

endmodule

### tb/sv/bad_sector_remap_table_core_tb.sv
// Testbench top for the bad sector remap table: clock, reset, stimulus and verdict.
module bad_sector_remap_table_core_tb;
   import bsrt_pkg::*;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PULSED
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int due_count;
   int checked_count;

   // stimulus bookkeeping
   int                  burst_left;
   logic [STRIDE_W-1:0] cur_stride;
   logic [SECTOR_W-1:0] bad_list [$];   // sectors sent for commit, reused for hits
   int                  items_sent;
   int                  commits_sent;
   int                  probes_sent;
   int                  settings_used;

   bsrt_req_if req_ch ();
   bsrt_rsp_if rsp_ch ();

   bad_sector_remap_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   bsrt_remap_checker remap_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .due_count     (due_count),
      .checked_count (checked_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Random sector, with both ends of the address space now and then.
   function automatic logic [SECTOR_W-1:0] rand_sector();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       rand_sector = '0;
         1:       rand_sector = '1;
         default: rand_sector = r[SECTOR_W-1:0];
      endcase
   endfunction

   // A sector already sent for commit, so lookups have a chance to hit.
   function automatic logic [SECTOR_W-1:0] known_sector();
      if (bad_list.size() == 0) known_sector = rand_sector();
      else known_sector = bad_list[$urandom_range(0, bad_list.size() - 1)];
   endfunction

   // One item: bursts of random length, random gaps between them. Inputs move
   // on the falling edge; the item is taken at a rising edge with ready high.
   task automatic send_item(input logic [KIND_W-1:0]   kind,
                            input logic [SECTOR_W-1:0] sec,
                            input logic [COUNT_W-1:0]  cnt);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid        = 1'b1;
      req_ch.kind         = kind;
      req_ch.sector       = sec;
      req_ch.sector_count = cnt;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (kind == KIND_COMMIT) begin
         bad_list.push_back(sec);
         commits_sent++;
      end
      if (kind == KIND_PROBE) probes_sent++;
   endtask

   // Hold off the sender until every result item has been taken.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (due_count == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_STRIDE) cur_stride = val[STRIDE_W-1:0];
   endtask

   // Receiver: switches among always ready, random stalls and a pulsed pattern.
   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             tick;
      rsp_ch.ready = 1'b0;
      mode         = READY_ALWAYS;
      mode_left    = 0;
      tick         = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 400);
         end
         mode_left--;
         tick++;
         case (mode)
            READY_ALWAYS: rsp_ch.ready = 1'b1;
            READY_RANDOM: rsp_ch.ready = ($urandom_range(0, 3) != 0);
            default:      rsp_ch.ready = ((tick % 9) < 3);
         endcase
      end
   end

   // Stimulus
   initial begin
      logic [KIND_W-1:0]   kind;
      logic [SECTOR_W-1:0] sec;
      logic [COUNT_W-1:0]  cnt;
      int                  eff;
      int                  span;
      int                  pick;
      int                  cs_pct;
      int                  n_items;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_FIRST_SECTOR;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_TRANSLATE;
      req_ch.sector       = '0;
      req_ch.sector_count = '0;
      burst_left          = 0;
      cur_stride          = STRIDE_W'(1);
      items_sent          = 0;
      commits_sent        = 0;
      probes_sent         = 0;
      settings_used       = 1;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // --- directed part ---
      // Reset state: no slots allowed, so everything that takes a slot is refused.
      send_item(KIND_PEEK,      48'h0000_1234_5678, 16'h0000);
      send_item(KIND_COMMIT,    48'h0000_0000_0123, 16'h0001);
      send_item(KIND_TRANSLATE, 48'h0000_0000_0123, 16'h0000);
      send_item(KIND_PROBE,     48'h0000_0000_0000, 16'hFFFF);

      // Replacement base two below the top, so slot addresses wrap; four slots;
      // zero stride, which must act as one.
      drain_results();
      write_reg(CSR_FIRST_SECTOR, 48'hFFFF_FFFF_FFFE);
      write_reg(CSR_SLOTS,        CSR_DATA_W'(4));
      write_reg(CSR_STRIDE,       CSR_DATA_W'(0));
      settings_used++;
      send_item(KIND_PEEK,      48'h0000_0000_0000, 16'h0000);
      send_item(KIND_COMMIT,    48'h0000_0000_0000, 16'h0000);
      send_item(KIND_COMMIT,    48'hFFFF_FFFF_FFFF, 16'h0000);
      send_item(KIND_COMMIT,    48'h0000_0000_0000, 16'h0000);  // duplicate, earliest wins
      send_item(KIND_SKIP,      48'h0000_0000_0042, 16'h0000);
      // table now exhausted
      send_item(KIND_PEEK,      48'h0000_0000_0099, 16'h0000);
      send_item(KIND_COMMIT,    48'h0000_0000_7777, 16'h0000);
      send_item(KIND_SKIP,      48'h0000_0000_0001, 16'h0000);
      send_item(KIND_TRANSLATE, 48'h0000_0000_0000, 16'h0000);
      send_item(KIND_TRANSLATE, 48'hFFFF_FFFF_FFFF, 16'h0000);
      send_item(KIND_TRANSLATE, 48'h0000_0000_0005, 16'h0000);
      // probes across the top of the address space
      send_item(KIND_PROBE,     48'hFFFF_FFFF_FFFD, 16'h0003);
      send_item(KIND_PROBE,     48'hFFFF_FFFF_FFFF, 16'h0002);
      send_item(KIND_PROBE,     48'hFFFF_FFFF_FFFE, 16'hFFFF);
      send_item(KIND_PROBE,     48'h0000_0000_0000, 16'h0000);  // empty range
      // undefined kinds change nothing
      for (int u = int'(KIND_SKIP) + 1; u < 2 ** KIND_W; u++) begin
         send_item(KIND_W'(u), rand_sector(), 16'hFFFF);
      end

      // --- random part: five register settings ---
      for (int phase = 0; phase < 5; phase++) begin
         drain_results();
         case (phase)
            0: begin
               write_reg(CSR_FIRST_SECTOR, rand_sector());
               write_reg(CSR_SLOTS,        CSR_DATA_W'(64));
               write_reg(CSR_STRIDE,       CSR_DATA_W'(1));
            end
            1: begin
               write_reg(CSR_FIRST_SECTOR, 48'hFFFF_FFFF_FF80);
               write_reg(CSR_SLOTS,        CSR_DATA_W'(128));
               write_reg(CSR_STRIDE,       CSR_DATA_W'($urandom_range(2, 16)));
            end
            2: begin
               // limit below the fill count: table reads as full
               write_reg(CSR_FIRST_SECTOR, 48'h0000_0000_0000);
               write_reg(CSR_SLOTS,        CSR_DATA_W'(1));
               write_reg(CSR_STRIDE,       CSR_DATA_W'(4096));
            end
            3: begin
               write_reg(CSR_FIRST_SECTOR, 48'hFFFF_FFFF_FFFF);
               write_reg(CSR_SLOTS,        CSR_DATA_W'(200));
               write_reg(CSR_STRIDE,       CSR_DATA_W'($urandom_range(1, 4096)));
            end
            default: begin
               // full table size; commit-heavy so the last slot gets used
               write_reg(CSR_FIRST_SECTOR, rand_sector());
               write_reg(CSR_SLOTS,        CSR_DATA_W'(256));
               write_reg(CSR_STRIDE,       CSR_DATA_W'($urandom_range(1, 64)));
            end
         endcase
         settings_used++;
         n_items = (phase == 4) ? 190 : ((phase == 2) ? 40 : 90);
         cs_pct  = (phase == 4) ? 80 : 40;
         for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < cs_pct * 3 / 4) kind = KIND_COMMIT;
            else if (pick < cs_pct) kind = KIND_SKIP;
            else begin
               pick = $urandom_range(0, 99);
               if (pick < 45) kind = KIND_TRANSLATE;
               else if (pick < 80) kind = KIND_PROBE;
               else if (pick < 92) kind = KIND_PEEK;
               else kind = KIND_W'($urandom_range(int'(KIND_SKIP) + 1, 2 ** KIND_W - 1));
            end
            cnt  = COUNT_W'($urandom);
            pick = $urandom_range(0, 99);
            case (kind)
               KIND_TRANSLATE: begin
                  if (pick < 55) sec = known_sector();
                  else if (pick < 70) sec = known_sector() + SECTOR_W'($urandom_range(0, 2)) - 1;
                  else sec = rand_sector();
               end
               KIND_PROBE: begin
                  eff = (cur_stride == '0) ? 1 : int'(cur_stride);
                  if (bad_list.size() > 0 && pick < 65) begin
                     // start a few strides below a known bad sector, sometimes off-grid
                     span = eff * $urandom_range(0, 6);
                     if ($urandom_range(0, 3) == 0) span += $urandom_range(0, eff - 1);
                     sec = known_sector() - SECTOR_W'(span);
                     cnt = COUNT_W'(span + $urandom_range(0, 2 * eff));
                  end else begin
                     sec = rand_sector();
                     if ($urandom_range(0, 3) != 0) cnt = COUNT_W'($urandom_range(0, 64));
                  end
               end
               KIND_COMMIT: begin
                  if (pick < 25) sec = known_sector();
                  else if (pick < 35) sec = known_sector() + SECTOR_W'($urandom_range(1, 8));
                  else sec = rand_sector();
               end
               default: sec = rand_sector();
            endcase
            send_item(kind, sec, cnt);
            // now and then let the block run dry before going on
            if ((phase == 0 && n == 45) || $urandom_range(0, 59) == 0) drain_results();
         end
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait (due_count == 0);
      repeat (300) @(posedge clock);
      $display("run covered %0d items (%0d commits, %0d probes) over %0d register settings",
               items_sent, commits_sent, probes_sent, settings_used);
      $display("%0d result items checked, %0d failures", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("** bad_sector_remap_table_core: PASSED **");
      end else begin
         $display("** bad_sector_remap_table_core: FAILED **");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #12000000;
      $display("** bad_sector_remap_table_core: FAILED **");
      $finish;
   end

endmodule

### filelist.f
rtl/core/bsrt_pkg.sv
rtl/core/bsrt_if.sv
rtl/core/bsrt_rem_pipe.sv
rtl/core/bsrt_datapath.sv
rtl/core/bsrt_ctrl.sv
rtl/core/bad_sector_remap_table_core.sv
tb/sv/bsrt_remap_checker.sv
tb/sv/bad_sector_remap_table_core_tb.sv
